FILE: src/q6d_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the quaternion to 6D rotation core.
// No dependencies.
package q6d_pkg;
   localparam int LANES = 6;
endpackage

FILE: src/q6d_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces for the quaternion to 6D rotation core.
// No dependencies.
interface q6d_req_if #(parameter int COMPONENT_WIDTH = 16);
   logic valid;
   logic ready;
   logic signed [COMPONENT_WIDTH-1:0] quat_x;
   logic signed [COMPONENT_WIDTH-1:0] quat_y;
   logic signed [COMPONENT_WIDTH-1:0] quat_z;
   logic signed [COMPONENT_WIDTH-1:0] quat_w;
   modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q6d_rsp_if #(parameter int COMPONENT_WIDTH = 16);
   logic valid;
   logic ready;
   logic signed [COMPONENT_WIDTH-1:0] row0_col0;
   logic signed [COMPONENT_WIDTH-1:0] row0_col1;
   logic signed [COMPONENT_WIDTH-1:0] row0_col2;
   logic signed [COMPONENT_WIDTH-1:0] row1_col0;
   logic signed [COMPONENT_WIDTH-1:0] row1_col1;
   logic signed [COMPONENT_WIDTH-1:0] row1_col2;
   logic zero_length;
   modport source (output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                   row1_col2, zero_length, input ready);
   modport sink (input valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                 row1_col2, zero_length, output ready);
endinterface

FILE: src/q6d_front.sv
`timescale 1ns / 1ps
// Front stages: products, numerators and norm, then division setup.
// Depends on q6d_pkg.
module q6d_front #(
   parameter int W = 16,
   parameter int Q = 15
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [W-1:0] x,
   input  logic signed [W-1:0] y,
   input  logic signed [W-1:0] z,
   input  logic signed [W-1:0] w,
   output logic out_valid,
   input  logic out_ready,
   output logic [2*W+1:0] out_d,
   output logic out_zero,
   output logic [q6d_pkg::LANES-1:0] out_neg,
   output logic [q6d_pkg::LANES-1:0][2*W+1:0] out_rem,
   output logic [q6d_pkg::LANES-1:0][Q-1:0] out_low
);
   import q6d_pkg::*;
   localparam int PW = 2 * W;
   localparam int N2W = 2 * W + 1;
   localparam int NUMW = 2 * W + 2;
   localparam int DW = N2W + 1;
   localparam int NW = N2W + Q + 1;

   logic signed [PW-1:0] xx_ff, yy_ff, zz_ff, ww_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;
   logic [N2W-1:0] n2_ff;
   logic signed [LANES-1:0][NUMW-1:0] num_ff;
   logic [N2W-1:0] n2_in;
   logic [LANES-1:0][NUMW-1:0] num_in;
   logic [DW-1:0] d_ff;
   logic zero_ff;
   logic [LANES-1:0] neg_ff;
   logic [LANES-1:0][DW-1:0] rem_ff;
   logic [LANES-1:0][Q-1:0] low_ff;
   logic [LANES-1:0] neg_in;
   logic [LANES-1:0][DW-1:0] rem_in;
   logic [LANES-1:0][Q-1:0] low_in;

   assign en3 = !v3_ff || out_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         xx_ff <= x * x;
         yy_ff <= y * y;
         zz_ff <= z * z;
         ww_ff <= w * w;
         xy_ff <= x * y;
         xz_ff <= x * z;
         yz_ff <= y * z;
         wx_ff <= w * x;
         wy_ff <= w * y;
         wz_ff <= w * z;
      end
   end

   always_comb begin
      n2_in = N2W'(unsigned'(xx_ff)) + N2W'(unsigned'(yy_ff))
            + N2W'(unsigned'(zz_ff)) + N2W'(unsigned'(ww_ff));
      num_in[0] = NUMW'(xx_ff) + NUMW'(ww_ff) - NUMW'(yy_ff) - NUMW'(zz_ff);
      num_in[1] = (NUMW'(xy_ff) - NUMW'(wz_ff)) <<< 1;
      num_in[2] = (NUMW'(xz_ff) + NUMW'(wy_ff)) <<< 1;
      num_in[3] = (NUMW'(xy_ff) + NUMW'(wz_ff)) <<< 1;
      num_in[4] = NUMW'(ww_ff) + NUMW'(yy_ff) - NUMW'(xx_ff) - NUMW'(zz_ff);
      num_in[5] = (NUMW'(yz_ff) - NUMW'(wx_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         n2_ff <= n2_in;
         num_ff <= num_in;
      end
   end

   always_comb begin
      logic [NUMW-1:0] mag;
      logic [NW-1:0] numer;
      for (int i = 0; i < LANES; i++) begin
         neg_in[i] = num_ff[i][NUMW-1];
         mag = neg_in[i] ? (~num_ff[i] + NUMW'(1)) : num_ff[i];
         numer = (NW'(mag[N2W-1:0]) << Q) + NW'(n2_ff);
         rem_in[i] = numer[NW-1:Q];
         low_in[i] = numer[Q-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         d_ff <= {n2_ff, 1'b0};
         zero_ff <= (n2_ff == '0);
         neg_ff <= neg_in;
         rem_ff <= rem_in;
         low_ff <= low_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_d = d_ff;
   assign out_zero = zero_ff;
   assign out_neg = neg_ff;
   assign out_rem = rem_ff;
   assign out_low = low_ff;
endmodule

FILE: src/q6d_div_cell.sv
`timescale 1ns / 1ps
// One restoring division cell: produces one quotient bit for all six lanes.
// Depends on q6d_pkg.
module q6d_div_cell #(
   parameter int DW = 34,
   parameter int Q = 15
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [DW-1:0] in_d,
   input  logic in_zero,
   input  logic [q6d_pkg::LANES-1:0] in_neg,
   input  logic [q6d_pkg::LANES-1:0][DW-1:0] in_rem,
   input  logic [q6d_pkg::LANES-1:0][Q-1:0] in_low,
   input  logic [q6d_pkg::LANES-1:0][Q-1:0] in_quot,
   output logic out_valid,
   input  logic out_ready,
   output logic [DW-1:0] out_d,
   output logic out_zero,
   output logic [q6d_pkg::LANES-1:0] out_neg,
   output logic [q6d_pkg::LANES-1:0][DW-1:0] out_rem,
   output logic [q6d_pkg::LANES-1:0][Q-1:0] out_low,
   output logic [q6d_pkg::LANES-1:0][Q-1:0] out_quot
);
   import q6d_pkg::*;
   logic v_ff, en;
   logic [DW-1:0] d_ff;
   logic zero_ff;
   logic [LANES-1:0] neg_ff;
   logic [LANES-1:0][DW-1:0] rem_ff, rem_in;
   logic [LANES-1:0][Q-1:0] low_ff, quot_ff, quot_in;

   assign en = !v_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      logic [DW:0] t;
      logic [DW:0] diff;
      logic ge;
      for (int i = 0; i < LANES; i++) begin
         t = {in_rem[i], in_low[i][Q-1]};
         diff = t - {1'b0, in_d};
         ge = t >= {1'b0, in_d};
         rem_in[i] = ge ? diff[DW-1:0] : t[DW-1:0];
         quot_in[i] = {in_quot[i][Q-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= in_d;
         zero_ff <= in_zero;
         neg_ff <= in_neg;
         rem_ff <= rem_in;
         for (int i = 0; i < LANES; i++) begin
            low_ff[i] <= {in_low[i][Q-2:0], 1'b0};
         end
         quot_ff <= quot_in;
      end
   end

   assign out_valid = v_ff;
   assign out_d = d_ff;
   assign out_zero = zero_ff;
   assign out_neg = neg_ff;
   assign out_rem = rem_ff;
   assign out_low = low_ff;
   assign out_quot = quot_ff;
endmodule

FILE: src/quaternion_to_rotation_6d_core.sv
`timescale 1ns / 1ps
// Quaternion to 6D rotation core: first two rotation matrix rows of a quaternion.
// Depends on q6d_pkg, q6d_if, q6d_front and q6d_div_cell.
//
// The request channel carries one quaternion (x, y, z, w), two's complement with
// FRACTION_BITS fraction bits. The response channel returns the six entries of
// rows 0 and 1, each rounded to nearest and saturated, plus zero_length, which is
// set when all four components are zero and the identity rows are returned.
// Both channels use a valid/ready handshake; a request is taken at a clock edge
// where both are high.
// A request passes three front stages (products, sums, division setup), one
// division cell per quotient bit (FRACTION_BITS + 1 cells), and the output register.
// Throughput is one request per cycle without stalls; every stage holds its own valid bit.
// When the receiver stalls, the response holds and the stages behind it fill up
// before req_chan.ready falls, so up to FRACTION_BITS + 5 requests can be in flight.
// Synchronous reset empties the pipeline; the block keeps no other state.
module quaternion_to_rotation_6d_core #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int FRACTION_BITS = 14
) (
   input logic clock,
   input logic reset,
   q6d_req_if.sink req_chan,
   q6d_rsp_if.source rsp_chan
);
   import q6d_pkg::*;
   localparam int W = COMPONENT_WIDTH;
   localparam int Q = FRACTION_BITS + 1;
   localparam int DW = 2 * W + 2;
   localparam int MW = ((Q > W) ? Q : W) + 1;

   logic [Q:0] c_valid, c_ready;
   logic [Q:0][DW-1:0] c_d;
   logic [Q:0] c_zero;
   logic [Q:0][LANES-1:0] c_neg;
   logic [Q:0][LANES-1:0][DW-1:0] c_rem;
   logic [Q:0][LANES-1:0][Q-1:0] c_low, c_quot;

   q6d_front #(.W(W), .Q(Q)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_chan.valid), .in_ready(req_chan.ready),
      .x(req_chan.quat_x), .y(req_chan.quat_y), .z(req_chan.quat_z), .w(req_chan.quat_w),
      .out_valid(c_valid[0]), .out_ready(c_ready[0]),
      .out_d(c_d[0]), .out_zero(c_zero[0]), .out_neg(c_neg[0]),
      .out_rem(c_rem[0]), .out_low(c_low[0])
   );
   assign c_quot[0] = '0;

   for (genvar g = 0; g < Q; g++) begin : g_cell
      q6d_div_cell #(.DW(DW), .Q(Q)) u_cell (
         .clock(clock), .reset(reset),
         .in_valid(c_valid[g]), .in_ready(c_ready[g]),
         .in_d(c_d[g]), .in_zero(c_zero[g]), .in_neg(c_neg[g]),
         .in_rem(c_rem[g]), .in_low(c_low[g]), .in_quot(c_quot[g]),
         .out_valid(c_valid[g+1]), .out_ready(c_ready[g+1]),
         .out_d(c_d[g+1]), .out_zero(c_zero[g+1]), .out_neg(c_neg[g+1]),
         .out_rem(c_rem[g+1]), .out_low(c_low[g+1]), .out_quot(c_quot[g+1])
      );
   end

   logic rsp_valid_ff, out_en;
   logic [LANES-1:0][W-1:0] row_ff, row_in;
   logic zero_ff;
   logic [MW-1:0] one_sat;

   assign out_en = !rsp_valid_ff || rsp_chan.ready;
   assign c_ready[Q] = out_en;

   always_comb begin
      logic [MW-1:0] mag, lim, m, v;
      logic [MW-1:0] one;
      one = MW'(1) << FRACTION_BITS;
      lim = MW'((1 << (W - 1)) - 1);
      one_sat = (one > lim) ? lim : one;
      for (int i = 0; i < LANES; i++) begin
         mag = MW'(c_quot[Q][i]);
         lim = c_neg[Q][i] ? (MW'(1) << (W - 1)) : MW'((1 << (W - 1)) - 1);
         m = (mag > lim) ? lim : mag;
         v = c_neg[Q][i] ? (~m + MW'(1)) : m;
         row_in[i] = v[W-1:0];
      end
      if (c_zero[Q]) begin
         row_in = '0;
         row_in[0] = one_sat[W-1:0];
         row_in[4] = one_sat[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= c_valid[Q];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         row_ff <= row_in;
         zero_ff <= c_zero[Q];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.row0_col0 = row_ff[0];
   assign rsp_chan.row0_col1 = row_ff[1];
   assign rsp_chan.row0_col2 = row_ff[2];
   assign rsp_chan.row1_col0 = row_ff[3];
   assign rsp_chan.row1_col1 = row_ff[4];
   assign rsp_chan.row1_col2 = row_ff[5];
   assign rsp_chan.zero_length = zero_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("response valid right after reset");
   a_zero_offdiag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && zero_ff |-> row_ff[1] == '0 && row_ff[2] == '0 && row_ff[3] == '0
                                 && row_ff[5] == '0)
      else $error("identity response has nonzero off-diagonal entry");
   a_zero_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && zero_ff |-> row_ff[0] == row_ff[4])
      else $error("identity response has unequal diagonal entries");
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> c_ready[Q])
      else $error("last division cell stalled with empty output register");
`endif
endmodule

FILE: tb/tb_quaternion_to_rotation_6d_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the quaternion to 6D rotation core.
// Depends on q6d_pkg, q6d_if and quaternion_to_rotation_6d_core.
module tb_quaternion_to_rotation_6d_core;
   import q6d_pkg::*;

   localparam int CW = 16;
   localparam int FB = 14;
   localparam int LATENCY = FB + 5;
   localparam longint CYCLE_LIMIT = 200000;

   typedef logic signed [CW-1:0] comp_t;

   typedef struct packed {
      comp_t r00, r01, r02, r10, r11, r12;
      logic zero_length;
   } pose_rows_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   longint cycle_count = 0;
   int error_count = 0;
   bit idle_enabled = 1'b1;
   pose_rows_t expected_rows[$];

   q6d_req_if #(.COMPONENT_WIDTH(CW)) req_chan ();
   q6d_rsp_if #(.COMPONENT_WIDTH(CW)) rsp_chan ();

   quaternion_to_rotation_6d_core #(.COMPONENT_WIDTH(CW), .FRACTION_BITS(FB)) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #2 clock = ~clock;

   function automatic comp_t rounded_entry(longint num, longint n2);
      bit negative;
      longint mag;
      longint quot;
      longint lim;
      negative = num < 0;
      mag = negative ? -num : num;
      quot = ((mag << (FB + 1)) + n2) / (2 * n2);
      lim = negative ? (longint'(1) << (CW - 1)) : (longint'(1) << (CW - 1)) - 1;
      if (quot > lim) quot = lim;
      return comp_t'(negative ? -quot : quot);
   endfunction

   function automatic pose_rows_t rotation_rows(comp_t qx, comp_t qy, comp_t qz, comp_t qw);
      longint x, y, z, w, n2;
      pose_rows_t r;
      longint one_code;
      x = qx;
      y = qy;
      z = qz;
      w = qw;
      n2 = x * x + y * y + z * z + w * w;
      if (n2 == 0) begin
         one_code = longint'(1) << FB;
         if (one_code > (longint'(1) << (CW - 1)) - 1) one_code = (longint'(1) << (CW - 1)) - 1;
         r.r00 = comp_t'(one_code);
         r.r11 = comp_t'(one_code);
         r.r01 = '0;
         r.r02 = '0;
         r.r10 = '0;
         r.r12 = '0;
         r.zero_length = 1'b1;
         return r;
      end
      r.r00 = rounded_entry(x * x + w * w - y * y - z * z, n2);
      r.r01 = rounded_entry(2 * (x * y - w * z), n2);
      r.r02 = rounded_entry(2 * (x * z + w * y), n2);
      r.r10 = rounded_entry(2 * (x * y + w * z), n2);
      r.r11 = rounded_entry(w * w + y * y - x * x - z * z, n2);
      r.r12 = rounded_entry(2 * (y * z - w * x), n2);
      r.zero_length = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= !(idle_enabled && $urandom_range(99) < 13);
   end

   always @(posedge clock) begin
      pose_rows_t got;
      pose_rows_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.row0_col0, rsp_chan.row0_col1, rsp_chan.row0_col2,
                 rsp_chan.row1_col0, rsp_chan.row1_col1, rsp_chan.row1_col2,
                 rsp_chan.zero_length};
         if (expected_rows.size() == 0) begin
            $display("%0t: response with no request pending, actual %h", $time, got);
            error_count++;
         end else begin
            want = expected_rows.pop_front();
            if (got.r00 !== want.r00)
               $display("%0t: row0_col0 expected %0d actual %0d", $time, want.r00, got.r00);
            if (got.r01 !== want.r01)
               $display("%0t: row0_col1 expected %0d actual %0d", $time, want.r01, got.r01);
            if (got.r02 !== want.r02)
               $display("%0t: row0_col2 expected %0d actual %0d", $time, want.r02, got.r02);
            if (got.r10 !== want.r10)
               $display("%0t: row1_col0 expected %0d actual %0d", $time, want.r10, got.r10);
            if (got.r11 !== want.r11)
               $display("%0t: row1_col1 expected %0d actual %0d", $time, want.r11, got.r11);
            if (got.r12 !== want.r12)
               $display("%0t: row1_col2 expected %0d actual %0d", $time, want.r12, got.r12);
            if (got.zero_length !== want.zero_length)
               $display("%0t: zero_length expected %0b actual %0b", $time,
                        want.zero_length, got.zero_length);
            if (got !== want) error_count++;
         end
      end
   end

   task automatic send_quaternion(comp_t qx, comp_t qy, comp_t qz, comp_t qw);
      while (idle_enabled && $urandom_range(99) < 13) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.quat_x <= qx;
      req_chan.quat_y <= qy;
      req_chan.quat_z <= qz;
      req_chan.quat_w <= qw;
      do @(posedge clock); while (!req_chan.ready);
      expected_rows.push_back(rotation_rows(qx, qy, qz, qw));
   endtask

   task automatic test_directed_cases();
      comp_t mx;
      comp_t mn;
      mx = comp_t'(16'sh7fff);
      mn = comp_t'(16'sh8000);
      send_quaternion(0, 0, 0, 0);
      send_quaternion(0, 0, 0, 16384);
      send_quaternion(16384, 0, 0, 0);
      send_quaternion(0, 16384, 0, 0);
      send_quaternion(0, 0, 16384, 0);
      send_quaternion(0, 0, 0, 1);
      send_quaternion(0, 0, 0, -1);
      send_quaternion(mx, mx, mx, mx);
      send_quaternion(mn, mn, mn, mn);
      send_quaternion(mn, mx, mn, mx);
      send_quaternion(mx, 0, 0, mn);
      send_quaternion(1, 1, 1, 1);
      send_quaternion(1, 2, 0, 0);
      send_quaternion(3, 0, 0, 1);
      send_quaternion(-1, 1, -1, 1);
      send_quaternion(11585, 0, 0, 11585);
      send_quaternion(0, -11585, 0, 11585);
      send_quaternion(8192, 8192, 8192, 8192);
      send_quaternion(mn, 0, 0, 0);
      send_quaternion(0, 0, 0, mn);
      send_quaternion(-5, 7, 1, 3);
   endtask

   task automatic test_random_unit_quaternions(int count);
      int k;
      for (k = 0; k < count; k++)
         send_quaternion(comp_t'($urandom_range(32767) - 16384),
                         comp_t'($urandom_range(32767) - 16384),
                         comp_t'($urandom_range(32767) - 16384),
                         comp_t'($urandom_range(32767) - 16384));
   endtask

   task automatic test_random_full_range(int count);
      int k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(9) == 0)
            send_quaternion(comp_t'($urandom_range(3) - 1), comp_t'($urandom_range(3) - 1),
                            comp_t'($urandom_range(3) - 1), comp_t'($urandom_range(3) - 1));
         else
            send_quaternion(comp_t'($urandom), comp_t'($urandom), comp_t'($urandom),
                            comp_t'($urandom));
      end
   endtask

   task automatic test_back_to_back(int count);
      idle_enabled = 1'b0;
      test_random_full_range(count);
      idle_enabled = 1'b1;
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.quat_x = '0;
      req_chan.quat_y = '0;
      req_chan.quat_z = '0;
      req_chan.quat_w = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_unit_quaternions(250);
      test_back_to_back(150);
      test_random_full_range(300);
      req_chan.valid <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (error_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
